@@ src/aspect_safe_resize_defines.svh @@
// ----------------------------------------------------------------------------
// aspect_safe_resize_defines.svh
// Assertion macros shared by the resize checker.
// ----------------------------------------------------------------------------
`ifndef ASPECT_SAFE_RESIZE_DEFINES_SVH
`define ASPECT_SAFE_RESIZE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ASR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define ASR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/asr_pkg.sv @@
// ----------------------------------------------------------------------------
// asr_pkg
// Widths, codes and controller/datapath interface types for the resizer.
// ----------------------------------------------------------------------------
package asr_pkg;

  localparam int DIM_BITS     = 13;
  localparam int PROD_BITS    = 2 * DIM_BITS;
  localparam int MAX_DEN      = 16;
  localparam int SCAN_BITS    = $clog2(MAX_DEN);
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
  localparam int TDATA_BITS   = ((PROD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS = 1;

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDEAL,
    DIV_MOD,
    DIV_HEIGHT
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_WAIT_IDEAL,
    S_CHECK,
    S_WAIT_MOD,
    S_SCAN,
    S_DEC,
    S_MULH,
    S_START_H,
    S_WAIT_H,
    S_FIN,
    S_FIN_ZERO
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_w_dw;
    logic     set_w_quot;
    logic     set_r;
    logic     scan_step;
    logic     dec_w;
    logic     mul_h;
    logic     set_out;
    logic     set_out_zero;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_src;
    logic less;
    logic w_zero;
    logic div_done;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/asr_div.sv @@
// ----------------------------------------------------------------------------
// asr_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module asr_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  asr_pkg::prod_t dividend,
  input  asr_pkg::dim_t  divisor,
  output asr_pkg::prod_t quotient,
  output asr_pkg::dim_t  remainder,
  output logic           done
);
  import asr_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  prod_t                   quo;
  dim_t                    rem;
  dim_t                    dvs;
  logic [DIM_BITS:0]       shifted;
  logic                    q_bit;
  dim_t                    rem_next;

  always_comb begin
    shifted = {rem, quo[PROD_BITS-1]};
    q_bit   = (shifted >= {1'b0, dvs});
    if (q_bit) begin
      rem_next = DIM_BITS'(shifted - {1'b0, dvs});
    end else begin
      rem_next = shifted[DIM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(PROD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[PROD_BITS-2:0], q_bit};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ src/asr_datapath.sv @@
// ----------------------------------------------------------------------------
// asr_datapath
// Source size registers, clamp, products, width search and output register.
// ----------------------------------------------------------------------------
module asr_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [asr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  asr_pkg::dim_t                    cfg_data,
  input  asr_pkg::dim_t                    in_width,
  input  asr_pkg::dim_t                    in_height,
  input  asr_pkg::ctrl_cmd_t               cmd,
  output asr_pkg::dp_status_t              status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output asr_pkg::dim_t                    out_width,
  output asr_pkg::dim_t                    out_height
);
  import asr_pkg::*;

  dim_t                 sw, sh;
  dim_t                 dw, dh;
  prod_t                prod_a, prod_b, prod_h;
  dim_t                 w;
  dim_t                 r;
  dim_t                 acc;
  dim_t                 acc_next;
  logic [DIM_BITS:0]    acc_sum;
  logic [SCAN_BITS-1:0] scan_cnt;
  prod_t                div_dividend;
  dim_t                 div_divisor;
  prod_t                div_quo;
  dim_t                 div_rem;
  logic                 div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= '0;
      sh <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SOURCE_WIDTH) begin
        sw <= cfg_data;
      end else begin
        sh <= cfg_data;
      end
    end
  end

  // candidate width w divides d*sw for some d up to the limit
  // exactly when d * (sw mod w) wraps to zero modulo w
  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, r};
    if (acc_sum >= {1'b0, w}) begin
      acc_next = DIM_BITS'(acc_sum - {1'b0, w});
    end else begin
      acc_next = acc_sum[DIM_BITS-1:0];
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_IDEAL: begin
        div_dividend = prod_b;
        div_divisor  = sh;
      end
      DIV_MOD: begin
        div_dividend = PROD_BITS'(sw);
        div_divisor  = w;
      end
      DIV_HEIGHT: begin
        div_dividend = prod_h;
        div_divisor  = sw;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = sw;
      end
    endcase
  end

  asr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dw <= (in_width  > sw) ? sw : in_width;
      dh <= (in_height > sh) ? sh : in_height;
    end
    if (cmd.mul) begin
      prod_a <= PROD_BITS'(dw) * PROD_BITS'(sh);
      prod_b <= PROD_BITS'(dh) * PROD_BITS'(sw);
    end
    if (cmd.mul_h) begin
      prod_h <= PROD_BITS'(sh) * PROD_BITS'(w);
    end
    if (cmd.set_w_dw) begin
      w <= dw;
    end else if (cmd.set_w_quot) begin
      w <= div_quo[DIM_BITS-1:0];
    end else if (cmd.dec_w) begin
      w <= w - 1'b1;
    end
    if (cmd.set_r) begin
      r        <= div_rem;
      acc      <= '0;
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      acc      <= acc_next;
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.set_out || cmd.set_out_zero) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_out_zero) begin
      out_width  <= '0;
      out_height <= '0;
    end else if (cmd.set_out) begin
      out_width  <= w;
      out_height <= div_quo[DIM_BITS-1:0];
    end
  end

  assign status.zero_src  = (sw == '0) || (sh == '0);
  assign status.less      = (prod_a < prod_b);
  assign status.w_zero    = (w == '0);
  assign status.div_done  = div_done;
  assign status.scan_hit  = (acc_next == '0);
  assign status.scan_last = (scan_cnt == SCAN_BITS'(MAX_DEN - 1));
  assign status.out_free  = !out_valid || out_ready;

endmodule

@@ src/asr_ctrl.sv @@
// ----------------------------------------------------------------------------
// asr_ctrl
// Sequencer for one resize request: compare, divide, search, recompute.
// ----------------------------------------------------------------------------
module asr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  asr_pkg::dp_status_t status,
  output asr_pkg::ctrl_cmd_t  cmd
);
  import asr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.zero_src ? S_FIN_ZERO : S_MUL;
        end
      end
      S_MUL:        state_next = S_CMP;
      S_CMP:        state_next = status.less ? S_CHECK : S_WAIT_IDEAL;
      S_WAIT_IDEAL: if (status.div_done) state_next = S_CHECK;
      S_CHECK:      state_next = status.w_zero ? S_MULH : S_WAIT_MOD;
      S_WAIT_MOD:   if (status.div_done) state_next = S_SCAN;
      S_SCAN: begin
        priority if (status.scan_hit) begin
          state_next = S_MULH;
        end else if (status.scan_last) begin
          state_next = S_DEC;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_DEC:        state_next = S_CHECK;
      S_MULH:       state_next = S_START_H;
      S_START_H:    state_next = S_WAIT_H;
      S_WAIT_H:     if (status.div_done) state_next = S_FIN;
      S_FIN:        if (status.out_free) state_next = S_IDLE;
      S_FIN_ZERO:   if (status.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_IDEAL;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MUL: cmd.mul = 1'b1;
      S_CMP: begin
        cmd.set_w_dw  = status.less;
        cmd.div_start = !status.less;
        cmd.div_sel   = DIV_IDEAL;
      end
      S_WAIT_IDEAL: cmd.set_w_quot = status.div_done;
      S_CHECK: begin
        cmd.div_start = !status.w_zero;
        cmd.div_sel   = DIV_MOD;
      end
      S_WAIT_MOD: cmd.set_r = status.div_done;
      S_SCAN:     cmd.scan_step = 1'b1;
      S_DEC:      cmd.dec_w = 1'b1;
      S_MULH:     cmd.mul_h = 1'b1;
      S_START_H: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_HEIGHT;
      end
      S_WAIT_H:   cmd.div_sel = DIV_HEIGHT;
      S_FIN:      cmd.set_out = status.out_free;
      S_FIN_ZERO: cmd.set_out_zero = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ src/aspect_safe_resize.sv @@
// ----------------------------------------------------------------------------
// aspect_safe_resize
// Aspect-preserving output size with a width of small reduced ratio.
// ----------------------------------------------------------------------------
// Usage: write source_width (index 0) and source_height (index 1) through
// cfg_we/cfg_index/cfg_data while idle. Each word on s_axis carries a
// requested width and height; one word with the safe width and height
// leaves on m_axis. One request is in flight at a time; s_axis_tready is
// high only while the sequencer waits for a request.
// Steps: the ideal width may take one 26-step division on the shared divider.
// Each candidate width tried takes a 26-step remainder on the shared
// divider plus 1 to 16 add-and-compare steps, and one more step to
// step down after a miss. The final height takes another 26-step division.
// N candidate widths are tried in turn; N can reach about 8000 when the
// source width is prime. All divisions run on the shared bit-serial divider.
// Reset clears the source size to zero and empties the output register.
// While m_axis is stalled the result word holds; the block may finish the
// next request and then waits until the held word is taken.
// ----------------------------------------------------------------------------
module aspect_safe_resize (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [asr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [asr_pkg::DIM_BITS-1:0]     cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [12:0] desired_width, [25:13] desired_height, [31:26] zero
  input  logic [asr_pkg::TDATA_BITS-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [12:0] safe_width, [25:13] safe_height, [31:26] zero
  output logic [asr_pkg::TDATA_BITS-1:0]   m_axis_tdata
);
  import asr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  dim_t       safe_width;
  dim_t       safe_height;

  asr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  asr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_width   (s_axis_tdata[DIM_BITS-1:0]),
    .in_height  (s_axis_tdata[PROD_BITS-1:DIM_BITS]),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_width  (safe_width),
    .out_height (safe_height)
  );

  assign m_axis_tdata = {{(TDATA_BITS - PROD_BITS){1'b0}}, safe_height, safe_width};

endmodule

@@ src/asr_checker.sv @@
// ----------------------------------------------------------------------------
// asr_checker
// Port-level checks on the resizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "aspect_safe_resize_defines.svh"

module asr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [asr_pkg::TDATA_BITS-1:0]   m_axis_tdata
);
  import asr_pkg::*;

  `ASR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")
  `ASR_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while one is in flight")
  `ASR_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[TDATA_BITS-1:PROD_BITS] == '0, "padding bits of result not zero")
  `ASR_ASSERT_NOW(a_zero_w_zero_h, m_axis_tvalid && (m_axis_tdata[DIM_BITS-1:0] == '0), m_axis_tdata[PROD_BITS-1:DIM_BITS] == '0, "zero width with nonzero height")

endmodule

bind aspect_safe_resize asr_checker u_asr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
